// ===== design/wsopm_pkg.sv =====
// Shared constants and the sine table generator for the wavetable sine oscillator.
package wsopm_pkg;

  localparam int TABLE_DEPTH_DEF     = 1024;
  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int FREQ_BITS  = 26;
  localparam int LEVEL_BITS = 16;
  localparam int AMP_BITS   = 16;
  localparam int LEVEL_FRAC = 14;
  localparam int AMP_FRAC   = 15;
  localparam int SCALE_SH   = LEVEL_FRAC + AMP_FRAC;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Shift-subtract quotient, used only while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic int sine_entry(int idx, int addr_bits, int sample_bits);
    logic [63:0]        t;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        kk;
    logic [1:0]         quad;
    logic signed [63:0] sum;
    logic signed [63:0] mag;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic               neg;
    int                 sh;
    t    = 64'(idx) << (32 - addr_bits);
    quad = t[31:30];
    r    = {34'd0, t[29:0]};
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = quad[0] ? (64'd1 << 30) : x;
    kk   = quad[0] ? 64'd1 : 64'd2;
    sum  = '0;
    neg  = 1'b0;
    for (int n = 0; n < 40; n++) begin
      if (term != 64'd0) begin
        sum  = neg ? (sum - $signed(term)) : (sum + $signed(term));
        neg  = !neg;
        term = udiv64((term * x2) >> 30, kk * (kk + 64'd1));
        kk   = kk + 64'd2;
      end
    end
    sh  = 30 - (sample_bits - 1);
    mag = (sum < 0) ? -sum : sum;
    mag = $signed(($unsigned(mag) + (64'd1 << (sh - 1))) >> sh);
    if (quad[1]) mag = -mag;
    if (sum < 0) mag = -mag;
    hi = (64'sd1 <<< (sample_bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (mag > hi) mag = hi;
    if (mag < lo) mag = lo;
    return int'(mag);
  endfunction

endpackage

// ===== design/wsopm_if.sv =====
// Request and result channel interfaces of the wavetable sine oscillator.
interface wsopm_in_if;
  import wsopm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [FREQ_BITS-1:0] freq_word;
  logic signed [FREQ_BITS-1:0] phase_mod;
  logic [LEVEL_BITS-1:0]       level;
  logic signed [AMP_BITS-1:0]  amp_sample;

  modport source (output valid, freq_word, phase_mod, level, amp_sample, input ready);
  modport sink   (input valid, freq_word, phase_mod, level, amp_sample, output ready);
endinterface

interface wsopm_out_if #(
  parameter int SAMPLE_BITS = wsopm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ===== design/wavetable_sine_oscillator_pm.sv =====
// Top level of the phase-modulated wavetable sine oscillator.
// Each request yields one sample: the phase accumulator picks two neighboring
// entries of a one-cycle sine table, the fraction interpolates between them,
// and the result is scaled by level and then by amp_sample, rounded and
// saturated. The phase then advances by freq_word + phase_mod, modulo the table
// length. Each request runs through four steps, the table read, the interpolation
// multiply and each of the two gain multiplies, all run one after another by a
// small sequencer. The next request is taken while the last result still waits
// in the output register; a result that is not taken holds the sequencer in its
// last step.
module wavetable_sine_oscillator_pm #(
  parameter int TABLE_DEPTH     = wsopm_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_FRAC_BITS = wsopm_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS     = wsopm_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsopm_in_if.sink     req_i,
  wsopm_out_if.source  res_o
);
  import wsopm_pkg::*;

  localparam int A     = $clog2(TABLE_DEPTH);
  localparam int F     = PHASE_FRAC_BITS;
  localparam int P     = A + F;
  localparam int S     = SAMPLE_BITS;
  localparam int SUM_W = ((P > FREQ_BITS) ? P : FREQ_BITS) + 2;
  localparam int D_W   = S + F + 2;
  localparam int P1_W  = S + LEVEL_BITS + 2;
  localparam int P2_W  = P1_W + AMP_BITS;

  localparam logic signed [D_W-1:0]  ROUND_F  = D_W'(1) << (F - 1);
  localparam logic signed [P2_W-1:0] ROUND_SC = P2_W'(1) << (SCALE_SH - 1);
  localparam logic signed [P2_W-1:0] OUT_MAX  = {{(P2_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [P2_W-1:0] OUT_MIN  = {{(P2_W-S+1){1'b1}}, {(S-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_INTERP,
    S_LEVEL,
    S_AMP
  } state_e;

  state_e                     state_q, state_d;
  logic [P-1:0]               phase_q, phase_d;
  logic [F-1:0]               frac_q, frac_d;
  logic [LEVEL_BITS-1:0]      level_q, level_d;
  logic signed [AMP_BITS-1:0] amp_q, amp_d;
  logic signed [S:0]          interp_q, interp_d;
  logic signed [P1_W-1:0]     p1_q, p1_d;
  logic signed [S-1:0]        sample_q, sample_d;
  logic                       out_valid_q, out_valid_d;

  logic                       accept;
  logic [A-1:0]               rd_idx;
  logic [A-1:0]               rd_nxt;
  logic signed [S-1:0]        v1;
  logic signed [S-1:0]        v2;
  logic [SUM_W-1:0]           phase_sum;
  logic signed [S:0]          delta;
  logic signed [D_W-1:0]      dprod;
  logic signed [D_W-1:0]      dround;
  logic signed [D_W-1:0]      dshift;
  logic signed [P2_W-1:0]     p2;
  logic signed [P2_W-1:0]     p2_round;
  logic signed [P2_W-1:0]     p2_shift;

  assign req_i.ready      = (state_q == S_IDLE);
  assign accept           = req_i.valid && req_i.ready;
  assign res_o.valid      = out_valid_q;
  assign res_o.sample_out = sample_q;

  assign rd_idx = phase_q[P-1:F];
  assign rd_nxt = rd_idx + A'(1);

  wsopm_rom #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ADDR_BITS   (A)
  ) u_wsopm_rom (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_a_addr_i (rd_idx),
    .rd_b_addr_i (rd_nxt),
    .rd_a_data_o (v1),
    .rd_b_data_o (v2)
  );

  always_comb begin
    phase_sum = SUM_W'(phase_q)
              + {{(SUM_W-FREQ_BITS){req_i.freq_word[FREQ_BITS-1]}}, req_i.freq_word}
              + {{(SUM_W-FREQ_BITS){req_i.phase_mod[FREQ_BITS-1]}}, req_i.phase_mod};
    delta     = {v2[S-1], v2} - {v1[S-1], v1};
    dprod     = D_W'(delta) * D_W'($signed({1'b0, frac_q}));
    dround    = dprod + ROUND_F;
    dshift    = dround >>> F;
    p2        = P2_W'(p1_q) * P2_W'(amp_q);
    p2_round  = p2 + ROUND_SC;
    p2_shift  = p2_round >>> SCALE_SH;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    frac_d      = frac_q;
    level_d     = level_q;
    amp_d       = amp_q;
    interp_d    = interp_q;
    p1_d        = p1_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && !res_o.ready;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          phase_d = phase_sum[P-1:0];
          frac_d  = phase_q[F-1:0];
          level_d = req_i.level;
          amp_d   = req_i.amp_sample;
          state_d = S_INTERP;
        end
      end
      S_INTERP: begin
        interp_d = {v1[S-1], v1} + dshift[S:0];
        state_d  = S_LEVEL;
      end
      S_LEVEL: begin
        p1_d    = P1_W'(interp_q) * P1_W'($signed({1'b0, level_q}));
        state_d = S_AMP;
      end
      S_AMP: begin
        if (!out_valid_q || res_o.ready) begin
          if (p2_shift > OUT_MAX) begin
            sample_d = OUT_MAX[S-1:0];
          end else if (p2_shift < OUT_MIN) begin
            sample_d = OUT_MIN[S-1:0];
          end else begin
            sample_d = p2_shift[S-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      frac_q      <= '0;
      level_q     <= '0;
      amp_q       <= '0;
      interp_q    <= '0;
      p1_q        <= '0;
      sample_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      frac_q      <= frac_d;
      level_q     <= level_d;
      amp_q       <= amp_d;
      interp_q    <= interp_d;
      p1_q        <= p1_d;
      sample_q    <= sample_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/wsopm_rom.sv =====
// One-cycle sine table with two registered read ports.
module wsopm_rom #(
  parameter int TABLE_DEPTH = wsopm_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = wsopm_pkg::SAMPLE_BITS_DEF,
  parameter int ADDR_BITS   = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [ADDR_BITS-1:0]          rd_a_addr_i,
  input  logic [ADDR_BITS-1:0]          rd_b_addr_i,
  output logic signed [SAMPLE_BITS-1:0] rd_a_data_o,
  output logic signed [SAMPLE_BITS-1:0] rd_b_data_o
);
  import wsopm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] rom_tbl [TABLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_a_q;
  logic signed [SAMPLE_BITS-1:0] rd_b_q;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
    localparam int Entry = sine_entry(g, ADDR_BITS, SAMPLE_BITS);
    assign rom_tbl[g] = SAMPLE_BITS'(Entry);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= rom_tbl[rd_a_addr_i];
      rd_b_q <= rom_tbl[rd_b_addr_i];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// ===== design/wsopm_checker.sv =====
// Port-level checks of the wavetable sine oscillator and their binding.
module wsopm_checker #(
  parameter int SAMPLE_BITS = wsopm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] sample_out_i
);
  import wsopm_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> $stable(sample_out_i))
    else $error("result payload changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("request taken while another is in flight");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 4))
    else $error("result appeared without a request four cycles before");

endmodule

bind wavetable_sine_oscillator_pm wsopm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wsopm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .sample_out_i (res_o.sample_out)
);
